@@ rtl/core/bfa_pkg.sv @@
// Shared types, field widths and operation codes of the bitmap frame allocator.
package bfa_pkg;

   localparam int ADDR_W           = 48;
   localparam int PAGES_W          = 36;
   localparam int MTYPE_W          = 8;
   localparam int OP_W             = 2;
   localparam int STATUS_W         = 2;
   localparam int FA_W             = 28;
   localparam int COUNT_W          = 17;
   localparam int PAGE_SHIFT       = 12;
   localparam int ALLOC_ROUND_LOG2 = 3;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REGION = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STS_OOM    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_REJECT = 2'd2;

   localparam logic [MTYPE_W-1:0] MT_LOADER_CODE  = 8'd1;
   localparam logic [MTYPE_W-1:0] MT_BOOT_CODE    = 8'd3;
   localparam logic [MTYPE_W-1:0] MT_CONVENTIONAL = 8'd7;

   localparam logic [ADDR_W-1:0]  ADDR_MAX  = 48'hffff_ffff_ffff;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1_ffff;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SPLIT,
      S_SCAN,
      S_FREE,
      S_REGION
   } bfa_state_type;

endpackage

@@ rtl/core/bitmap_frame_allocator.sv @@
// Bitmap page frame allocator: frame map memory, scan, free and region clear sequencer.
// Rejects and skipped regions raise rsp_valid in the cycle after the accept; allocate scans
// map words from word 0 up to the scan limit, free passes the index split and then reads and
// writes back one word, and add region passes the split and rewrites every map word touched.
// One item at a time; the map memory has one read and one write port, one word per cycle each.
// Reset: a clearing pass writes every map word to all ones, with busy high throughout.
module bitmap_frame_allocator import bfa_pkg::*; #(
   parameter int FRAME_COUNT   = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [PAGES_W-1:0]  req_page_count,
   input  logic [MTYPE_W-1:0]  req_memory_type,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FA_W-1:0]     rsp_frame_address,
   output logic [COUNT_W-1:0]  rsp_used_count
);

   localparam int MAP_WORDS = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
   localparam int FIDX_W    = $clog2(FRAME_COUNT + 1);
   localparam int BASE_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
   localparam int OFF_W     = $clog2(MAP_WORD_BITS);
   localparam int NB_W      = $clog2(MAP_WORD_BITS + 1);
   localparam int ESUM_W    = PAGES_W + 1;

   localparam logic [ADDR_W-1:0]  MAP_LIMIT = ADDR_W'(FRAME_COUNT) << PAGE_SHIFT;
   localparam logic [FIDX_W-1:0]  FRAME_TOP = FIDX_W'(FRAME_COUNT);
   localparam logic [WADDR_W-1:0] CLR_LAST  = WADDR_W'(MAP_WORDS - 1);
   localparam logic [BASE_W-1:0]  WB_BASE   = BASE_W'(MAP_WORD_BITS);
   localparam logic [1:0]         SPLIT_LAST = 2'd2;

   // mask with bits below n set
   function automatic logic [MAP_WORD_BITS-1:0] therm(input logic [NB_W-1:0] n);
      logic [MAP_WORD_BITS-1:0] t;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         t[b] = (NB_W'(b) < n);
      end
      return t;
   endfunction

   // ---------------------------------------------------------------- state
   bfa_state_type state_ff, state_in;

   logic [WADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [1:0]          split_cnt_ff, split_cnt_in;
   logic [ADDR_W-1:0]   end_address_ff, end_address_in;
   logic [COUNT_W-1:0]  used_ff, used_in;

   // request words captured at accept
   logic [OP_W-1:0]     op_ff;
   logic [FIDX_W-1:0]   lim_ff, lim_in;
   logic [FIDX_W-1:0]   s_ff, s_in;
   logic [FIDX_W-1:0]   e_ff, e_in;
   logic [ADDR_W:0]     region_sum_ff, region_sum_in;

   // read pipeline
   logic [WCNT_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [BASE_W-1:0]        iss_base_ff, iss_base_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [WADDR_W-1:0]       rd_word_ff, rd_word_in;
   logic [BASE_W-1:0]        eval_base_ff, eval_base_in;
   logic [MAP_WORD_BITS-1:0] rd_data_ff;

   // result word
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FA_W-1:0]     rsp_frame_ff, rsp_frame_in;

   // memory port
   logic [MAP_WORD_BITS-1:0] frame_mem [MAP_WORDS];
   logic                     mem_we, mem_re;
   logic [WADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [MAP_WORD_BITS-1:0] mem_wdata;

   // ---------------------------------------------------------------- accept decode
   logic              acc;
   logic              addr_in_map, free_ok, usable, region_ok;
   logic [ESUM_W-1:0] e_sum;

   assign busy = (state_ff != S_IDLE);
   assign acc  = start && !busy;

   assign addr_in_map = (req_address < MAP_LIMIT);
   assign free_ok     = addr_in_map && (req_address < end_address_ff)
                        && (req_address[PAGE_SHIFT-1:0] == '0);
   assign usable      = (req_memory_type == MT_CONVENTIONAL)
                        || (req_memory_type == MT_LOADER_CODE)
                        || (req_memory_type == MT_BOOT_CODE);
   assign region_ok   = addr_in_map && usable;

   // scan limit: whole map past the limit, else frame count rounded down to eight
   assign lim_in = (end_address_ff > MAP_LIMIT) ? FRAME_TOP :
                   FIDX_W'((end_address_ff >> (PAGE_SHIFT + ALLOC_ROUND_LOG2))
                           << ALLOC_ROUND_LOG2);

   assign s_in  = req_address[PAGE_SHIFT +: FIDX_W];
   assign e_sum = ESUM_W'(s_in) + ESUM_W'(req_page_count);
   assign e_in  = (e_sum > ESUM_W'(FRAME_COUNT)) ? FRAME_TOP : FIDX_W'(e_sum);
   assign region_sum_in = {1'b0, req_address}
                          + {1'b0, req_page_count, {PAGE_SHIFT{1'b0}}};

   // ---------------------------------------------------------------- index split
   logic [WCNT_W-1:0] ws_q, we_q, wend;
   logic [OFF_W-1:0]  ws_r, we_r;

   bfa_word_split #(
      .IDX_W     (FIDX_W),
      .WORD_BITS (MAP_WORD_BITS),
      .QUO_W     (WCNT_W)
   ) u_split_start (
      .clock     (clock),
      .frame_idx (s_ff),
      .word_idx  (ws_q),
      .bit_off   (ws_r)
   );

   bfa_word_split #(
      .IDX_W     (FIDX_W),
      .WORD_BITS (MAP_WORD_BITS),
      .QUO_W     (WCNT_W)
   ) u_split_end (
      .clock     (clock),
      .frame_idx (e_ff),
      .word_idx  (we_q),
      .bit_off   (we_r)
   );

   // exclusive end word of the region; a partial last word counts
   assign wend = we_q + WCNT_W'(we_r != '0);

   // ---------------------------------------------------------------- scan evaluation
   logic [BASE_W-1:0]        left;
   logic [NB_W-1:0]          n_valid;
   logic [MAP_WORD_BITS-1:0] avail, low_bit;
   logic [OFF_W-1:0]         pos;
   logic [BASE_W-1:0]        hit_idx;
   logic                     scan_issue, scan_hit;

   assign left    = BASE_W'(lim_ff) - eval_base_ff;
   assign n_valid = (left >= WB_BASE) ? NB_W'(MAP_WORD_BITS) : NB_W'(left);
   assign avail   = ~rd_data_ff & therm(n_valid);
   // isolate the lowest free bit
   assign low_bit = avail & (~avail + MAP_WORD_BITS'(1));

   always_comb begin
      pos = '0;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         if (low_bit[b]) begin
            pos = pos | OFF_W'(b);
         end
      end
   end

   assign hit_idx    = eval_base_ff + BASE_W'(pos);
   assign scan_issue = (iss_base_ff < BASE_W'(lim_ff));
   assign scan_hit   = rd_vld_ff && (avail != '0);

   // ---------------------------------------------------------------- region mask
   logic [WCNT_W-1:0]        rd_word_ext;
   logic [MAP_WORD_BITS-1:0] lo_mask, hi_mask, clr_mask;
   logic                     reg_issue;

   assign rd_word_ext = WCNT_W'(rd_word_ff);
   assign lo_mask   = (rd_word_ext == ws_q) ? ~therm(NB_W'(ws_r)) : '1;
   assign hi_mask   = ((rd_word_ext == we_q) && (we_r != '0)) ? therm(NB_W'(we_r)) : '1;
   assign clr_mask  = lo_mask & hi_mask;
   assign reg_issue = (rd_addr_ff < wend);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (acc) begin
               case (req_opcode)
                  OP_ALLOC:  state_in = S_SCAN;
                  OP_FREE:   state_in = free_ok ? S_SPLIT : S_IDLE;
                  OP_REGION: state_in = region_ok ? S_SPLIT : S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SPLIT: begin
            if (split_cnt_ff == SPLIT_LAST) begin
               state_in = (op_ff == OP_FREE) ? S_FREE : S_REGION;
            end
         end
         S_SCAN: begin
            if (scan_hit || !scan_issue) begin
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            state_in = S_IDLE;
         end
         S_REGION: begin
            if (!reg_issue) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath control
   always_comb begin
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = rd_word_ff;
      mem_wdata      = rd_data_ff;
      mem_raddr      = rd_addr_ff[WADDR_W-1:0];
      clr_addr_in    = clr_addr_ff;
      split_cnt_in   = '0;
      rd_addr_in     = rd_addr_ff;
      iss_base_in    = iss_base_ff;
      rd_vld_in      = 1'b0;
      rd_word_in     = mem_raddr;
      eval_base_in   = eval_base_ff;
      end_address_in = end_address_ff;
      used_in        = used_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STS_OK;
      rsp_frame_in   = '0;

      case (state_ff)
         S_CLEAR: begin
            // sweep the map to all ones, one word a cycle
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '1;
            clr_addr_in = clr_addr_ff + WADDR_W'(1);
         end
         S_IDLE: begin
            if (acc) begin
               rd_addr_in  = '0;
               iss_base_in = '0;
               case (req_opcode)
                  OP_ALLOC: begin
                  end
                  OP_FREE: begin
                     if (!free_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_REJECT;
                     end
                  end
                  OP_REGION: begin
                     // unusable or outside the map: answer ok, change nothing
                     if (!region_ok) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_REJECT;
                  end
               endcase
            end
         end
         S_SPLIT: begin
            split_cnt_in = split_cnt_ff + 2'd1;
            // raise the end address, saturating at the top of the address space
            if ((split_cnt_ff == '0) && (op_ff == OP_REGION)
                && (region_sum_ff > {1'b0, end_address_ff})) begin
               end_address_in = region_sum_ff[ADDR_W] ? ADDR_MAX : region_sum_ff[ADDR_W-1:0];
            end
            if (split_cnt_ff == SPLIT_LAST) begin
               rd_addr_in = ws_q;
               if (op_ff == OP_FREE) begin
                  mem_re     = 1'b1;
                  mem_raddr  = ws_q[WADDR_W-1:0];
                  rd_vld_in  = 1'b1;
                  rd_word_in = ws_q[WADDR_W-1:0];
               end
            end
         end
         S_SCAN: begin
            // read ahead one word while the previous word is checked
            if (scan_issue && !scan_hit) begin
               mem_re       = 1'b1;
               rd_addr_in   = rd_addr_ff + WCNT_W'(1);
               iss_base_in  = iss_base_ff + WB_BASE;
               rd_vld_in    = 1'b1;
               eval_base_in = iss_base_ff;
            end
            if (scan_hit) begin
               mem_we        = 1'b1;
               mem_wdata     = rd_data_ff | low_bit;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_frame_in  = FA_W'({hit_idx, {PAGE_SHIFT{1'b0}}});
               if (used_ff != COUNT_MAX) begin
                  used_in = used_ff + COUNT_W'(1);
               end
            end else if (!scan_issue) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OOM;
            end
         end
         S_FREE: begin
            mem_we        = 1'b1;
            mem_wdata     = rd_data_ff & ~(MAP_WORD_BITS'(1) << ws_r);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
            // drop the count even for a frame that was already free
            if (used_ff != '0) begin
               used_in = used_ff - COUNT_W'(1);
            end
         end
         S_REGION: begin
            if (reg_issue) begin
               mem_re     = 1'b1;
               rd_addr_in = rd_addr_ff + WCNT_W'(1);
               rd_vld_in  = 1'b1;
            end
            // write back the previous word with the region's frames cleared
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~clr_mask;
            end
            if (!reg_issue) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- frame map memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         split_cnt_ff   <= '0;
         end_address_ff <= '0;
         used_ff        <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         split_cnt_ff   <= split_cnt_in;
         end_address_ff <= end_address_in;
         used_ff        <= used_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         op_ff         <= req_opcode;
         lim_ff        <= lim_in;
         s_ff          <= s_in;
         e_ff          <= e_in;
         region_sum_ff <= region_sum_in;
      end
      rd_addr_ff    <= rd_addr_in;
      iss_base_ff   <= iss_base_in;
      rd_word_ff    <= rd_word_in;
      eval_base_ff  <= eval_base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_address = rsp_frame_ff;
   assign rsp_used_count    = used_ff;

   // ---------------------------------------------------------------- assertions
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("map read and write hit the same word in one cycle");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("map written while idle");

   a_used_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$stable(used_ff) |-> rsp_valid_ff)
      else $error("used count changed without a result word");

   a_frame_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_frame_ff != '0)) |-> (rsp_status_ff == STS_OK))
      else $error("frame address reported with a failing status");

endmodule

@@ rtl/core/bfa_word_split.sv @@
// Two-stage split of a frame index into map word index and bit offset.
module bfa_word_split #(
   parameter int IDX_W     = 17,
   parameter int WORD_BITS = 64,
   parameter int QUO_W     = 11
) (
   input  logic                         clock,
   input  logic [IDX_W-1:0]             frame_idx,
   output logic [QUO_W-1:0]             word_idx,
   output logic [$clog2(WORD_BITS)-1:0] bit_off
);

   localparam int OFF_W  = $clog2(WORD_BITS);
   localparam int PROD_W = 2 * IDX_W;
   localparam logic [IDX_W-1:0] RECIP = IDX_W'((1 << IDX_W) / WORD_BITS);
   localparam logic [IDX_W-1:0] WB    = IDX_W'(WORD_BITS);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  idx_d_ff;
   logic [IDX_W-1:0]  q_est, back, rem_raw;
   logic              fix;
   logic [QUO_W-1:0]  word_idx_ff, word_idx_in;
   logic [OFF_W-1:0]  bit_off_ff, bit_off_in;

   // reciprocal estimate is exact or one short
   assign prod_in = PROD_W'(frame_idx) * PROD_W'(RECIP);

   assign q_est   = prod_ff[PROD_W-1:IDX_W];
   assign back    = q_est * WB;
   assign rem_raw = idx_d_ff - back;
   assign fix     = (rem_raw >= WB);

   assign word_idx_in = QUO_W'(q_est) + QUO_W'(fix);
   assign bit_off_in  = OFF_W'(fix ? (rem_raw - WB) : rem_raw);

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      idx_d_ff    <= frame_idx;
      word_idx_ff <= word_idx_in;
      bit_off_ff  <= bit_off_in;
   end

   assign word_idx = word_idx_ff;
   assign bit_off  = bit_off_ff;

endmodule
